[sv/dda_pkg.sv]
// ---------------------------------------------------------------------------
// dda_pkg
// Shared types, constants and the quarter sine table for the ray stepper.
// ---------------------------------------------------------------------------
package dda_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned ANG_W  = 12;
  localparam int unsigned CELL_W = 9;
  localparam int unsigned DIST_W = 32;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [POS_W-1:0]  start_x;
    logic [POS_W-1:0]  start_y;
    logic [ANG_W-1:0]  angle;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              side;
    logic [DIST_W-1:0] distance;
    logic              out_of_map;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  // divider control between top and the serial divider
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  // sin(k*pi/64) in Q1.16, k = 0..32
  function automatic logic [16:0] sine_tab(input logic [5:0] k);
    logic [16:0] v;
    case (k)
      6'd0:  v = 17'd0;      6'd1:  v = 17'd3216;   6'd2:  v = 17'd6424;
      6'd3:  v = 17'd9616;   6'd4:  v = 17'd12785;  6'd5:  v = 17'd15924;
      6'd6:  v = 17'd19024;  6'd7:  v = 17'd22078;  6'd8:  v = 17'd25080;
      6'd9:  v = 17'd28020;  6'd10: v = 17'd30893;  6'd11: v = 17'd33692;
      6'd12: v = 17'd36410;  6'd13: v = 17'd39040;  6'd14: v = 17'd41576;
      6'd15: v = 17'd44011;  6'd16: v = 17'd46341;  6'd17: v = 17'd48559;
      6'd18: v = 17'd50660;  6'd19: v = 17'd52639;  6'd20: v = 17'd54491;
      6'd21: v = 17'd56212;  6'd22: v = 17'd57798;  6'd23: v = 17'd59244;
      6'd24: v = 17'd60547;  6'd25: v = 17'd61705;  6'd26: v = 17'd62714;
      6'd27: v = 17'd63572;  6'd28: v = 17'd64277;  6'd29: v = 17'd64827;
      6'd30: v = 17'd65220;  6'd31: v = 17'd65457;  6'd32: v = 17'd65536;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

[sv/dda_sine.sv]
// ---------------------------------------------------------------------------
// dda_sine
// Interpolated sine magnitude and sign for one 16-bit phase, registered.
// ---------------------------------------------------------------------------
module dda_sine (
  input  logic        clk,
  input  logic [15:0] phase,
  output logic [16:0] mag_r,
  output logic        neg_r
);

  logic [1:0]  quad;
  logic [13:0] p;
  logic [14:0] u;
  logic [5:0]  idx;
  logic [8:0]  frac;
  logic [16:0] a;
  logic [16:0] b;
  logic [25:0] prod;
  logic [16:0] mag_nxt;

  // fold the phase into the first quadrant and interpolate
  always_comb begin
    quad = phase[15:14];
    p    = phase[13:0];
    u    = quad[0] ? (15'd16384 - {1'b0, p}) : {1'b0, p};
    idx  = {1'b0, u[13:9]};
    frac = u[8:0];
    a    = dda_pkg::sine_tab(idx);
    b    = dda_pkg::sine_tab(idx + 6'd1);
    prod = 26'(b - a) * 26'(frac) + 26'd256;
    if (u[14]) begin
      mag_nxt = 17'd65536;
    end else begin
      mag_nxt = a + 17'(prod >> 9);
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= quad[1] && (mag_nxt != 17'd0);
  end

endmodule

[sv/dda_div.sv]
// ---------------------------------------------------------------------------
// dda_div
// Restoring bit-serial divider: floor(2^32 / mag), saturated, one bit a cycle.
// ---------------------------------------------------------------------------
module dda_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [16:0]       mag,
  output dda_pkg::div_ctl_t ctl,
  output logic [31:0]       quo_r
);

  logic [17:0] rem_r, rem_nxt;
  logic [16:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        sat_r;
  logic [18:0] trial;
  logic        bit_in;

  assign ctl.start = start;
  assign ctl.busy  = busy_r;

  // dividend is 2^32: a single one bit followed by zeros
  always_comb begin
    bit_in  = (cnt_r == 6'd33);
    trial   = {rem_r, bit_in} - {2'b00, den_r};
    rem_nxt = trial[18] ? {rem_r[16:0], bit_in} : trial[17:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd33;
      rem_r  <= '0;
      den_r  <= mag;
      sat_r  <= (mag <= 17'd1);
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        if (sat_r) quo_r <= 32'hFFFF_FFFF;
      end else begin
        quo_r <= {quo_r[30:0], ~trial[18]};
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

endmodule

[sv/dda_mul.sv]
// ---------------------------------------------------------------------------
// dda_mul
// Shift-add serial multiplier: (frac * delta) >> FRAC_BITS, saturated.
// ---------------------------------------------------------------------------
module dda_mul #(
  parameter int unsigned FB = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [FB:0]    frac,
  input  logic [31:0]    delta,
  output logic           busy_r,
  output logic [31:0]    res
);

  localparam int unsigned CW = $clog2(FB + 2);

  logic [FB:0]     mplr_r;
  logic [FB+32:0]  acc_r;
  logic [FB+32:0]  mcand_r;
  logic [CW-1:0]   cnt_r;
  logic [FB+32:0]  shifted;

  // one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      cnt_r   <= CW'(FB + 1);
      mplr_r  <= frac;
      mcand_r <= (FB+33)'(delta);
      acc_r   <= '0;
    end else if (busy_r) begin
      if (mplr_r[0]) acc_r <= acc_r + mcand_r;
      mplr_r  <= mplr_r >> 1;
      mcand_r <= mcand_r << 1;
      cnt_r   <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  assign shifted = acc_r >> FB;
  assign res = (shifted[FB+32:32] != '0) ? 32'hFFFF_FFFF : shifted[31:0];

endmodule

[sv/dda_ray_grid_stepper.sv]
// ---------------------------------------------------------------------------
// dda_ray_grid_stepper
// DDA ray walker over a square grid with serial divide and multiply units.
// ---------------------------------------------------------------------------
// channel | direction | payload
// in_     | input     | dda_pkg::in_item_t  (opcode, start_x, start_y, angle)
// out_    | output    | dda_pkg::out_item_t (cell_x, cell_y, side, distance, oom)
//
// step transaction: out_valid rises in the cycle after acceptance
// start transaction: per axis (x, then y) a table lookup, a serial divide and
// a serial multiply run before out_valid rises
// reset: synchronous rst_n clears control and ray state.
// one transaction in flight; in_ready drops until the result is taken.
// ---------------------------------------------------------------------------
module dda_ray_grid_stepper #(
  parameter int unsigned MAP_CELLS   = 256,
  parameter int unsigned ANGLE_STEPS = 4096,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dda_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dda_pkg::out_item_t out_data
);

  localparam int unsigned PW = dda_pkg::POS_W;

  dda_pkg::state_t st_r, st_nxt;
  dda_pkg::in_item_t item_r;
  logic        res_side_r;
  logic [31:0] res_dist_r;

  logic signed [9:0] cx_r, cy_r;
  logic        nx_r, ny_r;
  logic [31:0] dx_r, dy_r, sx_r, sy_r;
  logic        side_r;
  logic        axis_r;   // 0 working x, 1 working y
  logic [15:0] phase, ph_sel;
  logic [16:0] mag;
  logic        mneg;
  logic        div_go, mul_go, dbusy_w;
  dda_pkg::div_ctl_t dctl;
  logic [31:0] quo;
  logic        mbusy;
  logic [31:0] mres;
  logic [PW-1:0] pos_sel;
  logic [FRAC_BITS:0] frac;
  logic        neg_sel;
  logic        launched_r;
  logic        trig_r;   // sine register holds the current axis

  // phase from binary angle
  always_comb begin
    logic [47:0] a;
    a     = 48'(item_r.angle % ANGLE_STEPS) * 48'd65536;
    phase = 16'(a / ANGLE_STEPS);
    ph_sel = axis_r ? phase : (phase + 16'd16384);
  end

  dda_sine u_sine (.clk(clk), .phase(ph_sel), .mag_r(mag), .neg_r(mneg));

  dda_div u_div (.clk(clk), .rst_n(rst_n), .start(div_go), .mag(mag),
                 .ctl(dctl), .quo_r(quo));
  assign dbusy_w = dctl.busy;

  always_comb begin
    pos_sel = axis_r ? item_r.start_y : item_r.start_x;
    neg_sel = axis_r ? ny_r : nx_r;
    frac = neg_sel ? {1'b0, pos_sel[FRAC_BITS-1:0]}
                   : ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, pos_sel[FRAC_BITS-1:0]};
  end

  dda_mul #(.FB(FRAC_BITS)) u_mul (.clk(clk), .rst_n(rst_n), .start(mul_go),
    .frac(frac), .delta(quo), .busy_r(mbusy), .res(mres));

  function automatic logic [9:0] sat_cell(input logic [PW-1:0] p);
    logic [PW-FRAC_BITS-1:0] c;
    c = p[PW-1:FRAC_BITS];
    return ((PW-FRAC_BITS+1)'(c) > (PW-FRAC_BITS+1)'(MAP_CELLS)) ?
           10'(MAP_CELLS) : 10'(c);
  endfunction

  function automatic logic outside(input logic signed [9:0] c);
    return (c < 0) || (c >= $signed(11'(MAP_CELLS)));
  endfunction

  // sequencer
  always_comb begin
    st_nxt   = st_r;
    in_ready = (st_r == dda_pkg::ST_IDLE);
    div_go   = 1'b0;
    mul_go   = 1'b0;
    case (st_r)
      dda_pkg::ST_IDLE: if (in_valid) begin
        st_nxt = (in_data.opcode == dda_pkg::OP_START) ? dda_pkg::ST_TRIG
                                                        : dda_pkg::ST_OUT;
      end
      dda_pkg::ST_TRIG: if (trig_r) begin
        div_go = 1'b1;
        st_nxt = dda_pkg::ST_DIV;
      end
      dda_pkg::ST_DIV: if (!dbusy_w && !launched_r) begin
        mul_go = 1'b1;
        st_nxt = dda_pkg::ST_MUL;
      end
      dda_pkg::ST_MUL: if (!mbusy && !launched_r) begin
        st_nxt = axis_r ? dda_pkg::ST_OUT : dda_pkg::ST_TRIG;
      end
      dda_pkg::ST_OUT: if (out_ready) st_nxt = dda_pkg::ST_IDLE;
      default: st_nxt = dda_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = (st_r == dda_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dda_pkg::ST_IDLE;
      launched_r <= 1'b0;
      trig_r <= 1'b0;
      axis_r <= 1'b0;
      cx_r <= '0; cy_r <= '0; nx_r <= 1'b0; ny_r <= 1'b0;
      dx_r <= '0; dy_r <= '0; sx_r <= '0; sy_r <= '0; side_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      launched_r <= div_go || mul_go;
      trig_r <= (st_r == dda_pkg::ST_TRIG) && !trig_r;
      case (st_r)
        dda_pkg::ST_IDLE: if (in_valid) begin
          item_r <= in_data;
          axis_r <= 1'b0;
          if (in_data.opcode == dda_pkg::OP_STEP) begin
            if (!outside(cx_r) && !outside(cy_r)) begin
              if (sx_r < sy_r) begin
                res_dist_r <= sx_r;
                sx_r <= ({1'b0, sx_r} + {1'b0, dx_r} > 33'hFFFF_FFFF) ?
                        32'hFFFF_FFFF : sx_r + dx_r;
                cx_r <= nx_r ? cx_r - 10'sd1 : cx_r + 10'sd1;
                side_r <= 1'b0;
                res_side_r <= 1'b0;
              end else begin
                res_dist_r <= sy_r;
                sy_r <= ({1'b0, sy_r} + {1'b0, dy_r} > 33'hFFFF_FFFF) ?
                        32'hFFFF_FFFF : sy_r + dy_r;
                cy_r <= ny_r ? cy_r - 10'sd1 : cy_r + 10'sd1;
                side_r <= 1'b1;
                res_side_r <= 1'b1;
              end
            end else begin
              res_dist_r <= '0;
              res_side_r <= side_r;
            end
          end
        end
        dda_pkg::ST_TRIG: if (trig_r) begin
          if (axis_r) ny_r <= mneg; else nx_r <= mneg;
        end
        dda_pkg::ST_DIV: if (!dbusy_w && !launched_r) begin
          if (axis_r) dy_r <= quo; else dx_r <= quo;
        end
        dda_pkg::ST_MUL: if (!mbusy && !launched_r) begin
          if (axis_r) begin
            sy_r <= mres;
            cx_r <= sat_cell(item_r.start_x);
            cy_r <= sat_cell(item_r.start_y);
            side_r <= 1'b0;
            res_side_r <= 1'b0;
            res_dist_r <= '0;
          end else begin
            sx_r <= mres;
          end
          axis_r <= ~axis_r;
        end
        default: ;
      endcase
    end
  end

  // cell and out_of_map fields follow the live cell state
  always_comb begin
    out_data.cell_x     = 9'(cx_r + 10'sd1);
    out_data.cell_y     = 9'(cy_r + 10'sd1);
    out_data.side       = res_side_r;
    out_data.distance   = res_dist_r;
    out_data.out_of_map = outside(cx_r) || outside(cy_r);
  end

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(dbusy_w && mbusy)) else $error("divider and multiplier both busy");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accepting while result pending");
  a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.opcode == dda_pkg::OP_STEP) |=> out_valid)
    else $error("step did not produce a result next cycle");

endmodule

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Checks the DDA ray stepper: a queue-fed driver sends start and step
// transactions, an in-file predictor walks each ray and a monitor compares
// every result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MAP_N = 256;
  localparam int unsigned FRAC  = 16;
  localparam longint unsigned SAT = 64'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  dda_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  dda_pkg::out_item_t out_data;

  dda_ray_grid_stepper uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  int ray_cx, ray_cy;
  logic ray_negx, ray_negy;
  logic [31:0] ray_dx, ray_dy, ray_sx, ray_sy;
  logic ray_side;

  dda_pkg::in_item_t pending_items[$];
  dda_pkg::out_item_t expected_hits[$];
  int errors;
  int unsigned cycles;
  logic stim_done;
  logic hold_in;
  logic in_ready_q;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned sine_lut(input int unsigned k);
    int unsigned t[33] = '{0, 3216, 6424, 9616, 12785, 15924, 19024, 22078,
      25080, 28020, 30893, 33692, 36410, 39040, 41576, 44011, 46341, 48559,
      50660, 52639, 54491, 56212, 57798, 59244, 60547, 61705, 62714, 63572,
      64277, 64827, 65220, 65457, 65536};
    return t[k];
  endfunction

  // sine table, quarter turn in Q1.16
  function automatic int unsigned quarter_sin(input int unsigned u);
    int unsigned idx, fr, lo, hi;
    if (u >= 16384) return 65536;
    idx = u >> 9;
    fr = u & 511;
    lo = sine_lut(idx);
    hi = sine_lut(idx + 1);
    return lo + (((hi - lo) * fr + 256) >> 9);
  endfunction

  function automatic int unsigned turn_sin(input int unsigned ph, output logic neg);
    int unsigned q, p, m;
    q = (ph >> 14) & 3;
    p = ph & 16'h3FFF;
    m = (q & 1) ? quarter_sin(16384 - p) : quarter_sin(p);
    neg = (q >= 2) && (m != 0);
    return m;
  endfunction

  function automatic logic [31:0] inv_mag(input int unsigned mag);
    longint unsigned q;
    if (mag == 0) return 32'hFFFF_FFFF;
    q = (64'd1 << 32) / mag;
    return (q > SAT) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] sum_sat(input logic [31:0] a, input logic [31:0] b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > SAT) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] first_edge(input logic [23:0] pos, input logic neg,
                                             input logic [31:0] d);
    longint unsigned f, r;
    f = pos[FRAC-1:0];
    r = ((neg ? f : (64'd1 << FRAC) - f) * longint'(d)) >> FRAC;
    return (r > SAT) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic bit off_grid(input int c);
    return c < 0 || c >= int'(MAP_N);
  endfunction

  // walk the ray one transaction ahead
  task automatic predict_ray(input dda_pkg::in_item_t it);
    dda_pkg::out_item_t r;
    int unsigned ph, mx, my, cx, cy;
    logic [31:0] step_dist;
    step_dist = 0;
    if (it.opcode == dda_pkg::OP_START) begin
      ph = (it.angle * 65536 / 4096) & 16'hFFFF;
      mx = turn_sin((ph + 16384) & 16'hFFFF, ray_negx);
      my = turn_sin(ph, ray_negy);
      cx = it.start_x >> FRAC;
      cy = it.start_y >> FRAC;
      ray_cx = (cx > MAP_N) ? MAP_N : cx;
      ray_cy = (cy > MAP_N) ? MAP_N : cy;
      ray_dx = inv_mag(mx);
      ray_dy = inv_mag(my);
      ray_sx = first_edge(it.start_x, ray_negx, ray_dx);
      ray_sy = first_edge(it.start_y, ray_negy, ray_dy);
      ray_side = 1'b0;
    end else if (!off_grid(ray_cx) && !off_grid(ray_cy)) begin
      if (ray_sx < ray_sy) begin
        step_dist = ray_sx;
        ray_sx = sum_sat(ray_sx, ray_dx);
        ray_cx += ray_negx ? -1 : 1;
        ray_side = 1'b0;
      end else begin
        step_dist = ray_sy;
        ray_sy = sum_sat(ray_sy, ray_dy);
        ray_cy += ray_negy ? -1 : 1;
        ray_side = 1'b1;
      end
    end
    r.cell_x = 9'(ray_cx + 1);
    r.cell_y = 9'(ray_cy + 1);
    r.side = ray_side;
    r.distance = step_dist;
    r.out_of_map = off_grid(ray_cx) || off_grid(ray_cy);
    expected_hits.push_back(r);
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic dda_pkg::in_item_t make_item(input logic op, input logic [23:0] x,
                                                  input logic [23:0] y,
                                                  input logic [11:0] a);
    dda_pkg::in_item_t it;
    it.opcode = op; it.start_x = x; it.start_y = y; it.angle = a;
    return it;
  endfunction

  // stimulus
  initial begin
    int n, k, steps;
    logic [23:0] x, y;
    // directed: extremes, axis angles, stepping off the map, step before start
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'hFFFFFF, 24'h0, 12'hFFF));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'h0, 24'h0, 12'h0));
    pending_items.push_back(make_item(dda_pkg::OP_START, 24'h0, 24'h0, 12'd0));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'h0, 24'h0, 12'd0));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'h0, 24'h0, 12'd0));
    pending_items.push_back(make_item(dda_pkg::OP_START, 24'h808000, 24'h7F8000, 12'd1024));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'h0, 24'h0, 12'd0));
    pending_items.push_back(make_item(dda_pkg::OP_START, 24'h000000, 24'h000000, 12'd2048));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'hFFFFFF, 24'hFFFFFF, 12'hFFF));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'h0, 24'h0, 12'd0));
    pending_items.push_back(make_item(dda_pkg::OP_START, 24'h010000, 24'h010000, 12'd3072));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'h0, 24'h0, 12'd0));
    pending_items.push_back(make_item(dda_pkg::OP_START, 24'hFFFFFF, 24'hFFFFFF, 12'hFFF));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'h0, 24'h0, 12'd0));
    pending_items.push_back(make_item(dda_pkg::OP_START, 24'h00FFFF, 24'h00FFFF, 12'd512));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'h0, 24'h0, 12'd0));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'h0, 24'h0, 12'd0));
    pending_items.push_back(make_item(dda_pkg::OP_START, 24'h0, 24'h7FFFFF, 12'd1536));
    pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'h0, 24'h0, 12'd0));
    // random rays: mostly start then a run of steps, some noise
    n = 0;
    while (n < 1200) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(make_item(1'($urandom_range(0, 1)), 24'($urandom),
                                          24'($urandom), 12'($urandom)));
        n++;
      end else begin
        x = 24'($urandom);
        y = 24'($urandom);
        if ($urandom_range(0, 3) != 0) begin
          x[23:20] = 4'h0;
          y[23:20] = 4'h0;
        end
        pending_items.push_back(make_item(dda_pkg::OP_START, x, y, 12'($urandom)));
        steps = $urandom_range(1, 40);
        for (k = 0; k < steps; k++)
          pending_items.push_back(make_item(dda_pkg::OP_STEP, 24'($urandom),
                                            24'($urandom), 12'($urandom)));
        n += steps + 1;
      end
    end
  end

  // reset
  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // driver
  int unsigned in_gap;
  int unsigned sent;
  initial begin
    in_valid = 1'b0;
    in_data = '0;
    in_gap = 0;
    sent = 0;
    hold_in = 1'b0;
    stim_done = 1'b0;
    // predictor starts from the reset state
    ray_cx = 0; ray_cy = 0;
    ray_negx = 1'b0; ray_negy = 1'b0;
    ray_dx = '0; ray_dy = '0; ray_sx = '0; ray_sy = '0;
    ray_side = 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_q) begin
        in_gap = pick_gap();
      end
      if (!(in_valid && !in_ready_q)) begin
        if (hold_in) begin
          if (expected_hits.size() == 0) hold_in = 1'b0;
          in_valid <= 1'b0;
        end else if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          sent++;
          if (sent == 600) hold_in = 1'b1;
        end else begin
          in_valid <= 1'b0;
          stim_done = 1'b1;
        end
      end
    end
  end

  // acceptance seen at the rising edge
  initial in_ready_q = 1'b0;
  always @(posedge clk) begin
    in_ready_q <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) predict_ray(in_data);
  end

  // result side stalls
  int unsigned out_gap;
  initial begin
    out_ready = 1'b0;
    out_gap = 0;
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    dda_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data);
        errors++;
      end else begin
        e = expected_hits.pop_front();
        if (out_data.cell_x !== e.cell_x)
          $display("%0t cell_x exp %0d got %0d", $time, e.cell_x, out_data.cell_x);
        if (out_data.cell_y !== e.cell_y)
          $display("%0t cell_y exp %0d got %0d", $time, e.cell_y, out_data.cell_y);
        if (out_data.side !== e.side)
          $display("%0t side exp %0d got %0d", $time, e.side, out_data.side);
        if (out_data.distance !== e.distance)
          $display("%0t distance exp %h got %h", $time, e.distance, out_data.distance);
        if (out_data.out_of_map !== e.out_of_map)
          $display("%0t out_of_map exp %0d got %0d", $time, e.out_of_map,
                   out_data.out_of_map);
        if (out_data !== e) errors++;
      end
    end
  end

  // end of run and timeout
  initial begin
    errors = 0;
    cycles = 0;
    while (!(stim_done && !in_valid && expected_hits.size() == 0) &&
           cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
    end else begin
      repeat (150) @(posedge clk);
      if (errors == 0 && expected_hits.size() == 0)
        $display("tb: clean");
      else
        $display("tb: errors");
    end
    $finish;
  end

endmodule
